>>> design/omf_dh_pkg.sv
// shared types, constants and rotate helpers for the dictionary hash block
package omf_dh_pkg;

	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [5:0] BUCKETS = 6'd37;
	// floor(x / 37) equals (x * BUCKET_RECIP) >> 21 for any 16-bit x
	localparam logic [15:0] BUCKET_RECIP = 16'd56680;
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW = 1;

	typedef struct packed {
		logic [15:0] page_class;
		logic [15:0] page_inc;
		logic [15:0] bucket_class;
		logic [15:0] bucket_inc;
		logic        too_long;
	} hash_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_HOLD
	} back_state_t;

	// rotate left by 2*k
	function automatic logic [15:0] rotl2k(input logic [15:0] v, input logic [2:0] k);
		logic [31:0] d;
		d = {v, v} << {k, 1'b0};
		return d[31:16];
	endfunction

	// rotate right by 2*k
	function automatic logic [15:0] rotr2k(input logic [15:0] v, input logic [2:0] k);
		logic [31:0] d;
		d = {v, v} >> {k, 1'b0};
		return d[15:0];
	endfunction

endpackage

>>> design/omf_dh_front.sv
// front end: per-byte hash accumulators, builds one entry per name
module omf_dh_front #(
	parameter int unsigned MAX_NAME_LEN = 255
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               name_byte,
	input  logic                     last_byte,
	output logic                     entry_push,
	output omf_dh_pkg::hash_entry_t  entry
);

	localparam logic [16:0] MAX_LEN = 17'(MAX_NAME_LEN);

	logic [15:0] rotl_sum_q, rotr_sum_q, rotl_chain_q, rotr_chain_q, cnt_q;
	logic        flag_q;

	logic [15:0] c, rotl_sum_d, rotr_sum_d, n, seed;
	logic [2:0]  k2;
	logic        cnt_ok, chain_upd;

	always_comb begin
		c = {8'h00, name_byte | omf_dh_pkg::CASE_BIT};
		cnt_ok = {1'b0, cnt_q} < MAX_LEN;
		chain_upd = cnt_ok && !last_byte && (({1'b0, cnt_q} + 17'd1) < MAX_LEN);
		rotl_sum_d = cnt_ok ? (rotl_sum_q ^ omf_dh_pkg::rotl2k(c, cnt_q[2:0])) : rotl_sum_q;
		rotr_sum_d = cnt_ok ? (rotr_sum_q ^ omf_dh_pkg::rotr2k(c, cnt_q[2:0])) : rotr_sum_q;
		n = cnt_ok ? (cnt_q + 16'd1) : cnt_q;
		seed = n | {8'h00, omf_dh_pkg::CASE_BIT};
		k2 = n[2:0] - 3'd1;
		entry.page_class = omf_dh_pkg::rotl2k(seed, k2) ^ rotl_chain_q;
		entry.bucket_inc = omf_dh_pkg::rotr2k(seed, k2) ^ rotr_chain_q;
		entry.page_inc = rotl_sum_d;
		entry.bucket_class = rotr_sum_d;
		entry.too_long = flag_q | ~cnt_ok;
		entry_push = accept & last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotl_sum_q <= '0;
			rotr_sum_q <= '0;
			rotl_chain_q <= '0;
			rotr_chain_q <= '0;
			cnt_q <= '0;
			flag_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				rotl_sum_q <= '0;
				rotr_sum_q <= '0;
				rotl_chain_q <= '0;
				rotr_chain_q <= '0;
				cnt_q <= '0;
				flag_q <= 1'b0;
			end else begin
				rotl_sum_q <= rotl_sum_d;
				rotr_sum_q <= rotr_sum_d;
				cnt_q <= n;
				flag_q <= entry.too_long;
				if (chain_upd) begin
					rotl_chain_q <= c ^ omf_dh_pkg::rotl2k(rotl_chain_q, 3'd1);
					rotr_chain_q <= c ^ omf_dh_pkg::rotr2k(rotr_chain_q, 3'd1);
				end
			end
		end
	end

endmodule

>>> design/omf_dh_queue.sv
// short queue of finished name hashes between front and back end
module omf_dh_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  omf_dh_pkg::hash_entry_t  wr_entry,
	input  logic                     pop,
	output omf_dh_pkg::hash_entry_t  rd_entry,
	output logic                     full,
	output logic                     empty
);

	omf_dh_pkg::hash_entry_t         slot_q [omf_dh_pkg::Q_DEPTH];
	logic [omf_dh_pkg::Q_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [omf_dh_pkg::Q_AW:0]       count_q;

	assign full = count_q == (omf_dh_pkg::Q_AW+1)'(omf_dh_pkg::Q_DEPTH);
	assign empty = count_q == '0;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/omf_dh_back.sv
// back end: bit-serial remainders by page count, reciprocal remainders by 37, result register
module omf_dh_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [15:0]              page_count,
	input  logic                     q_empty,
	input  omf_dh_pkg::hash_entry_t  q_entry,
	output logic                     q_pop,
	input  logic                     pop,
	output logic                     empty,
	output logic [15:0]              page_index,
	output logic [15:0]              page_step,
	output logic [5:0]               bucket_index,
	output logic [5:0]               bucket_step,
	output logic                     name_too_long
);

	omf_dh_pkg::back_state_t state_q, state_d;

	logic [15:0] div_q;
	logic [15:0] pi_num_q, ps_num_q, bi_num_q, bs_num_q;
	logic [15:0] pi_rem_q, ps_rem_q;
	logic [10:0] bi_quo_q, bs_quo_q;
	logic [5:0]  bi_rem_q, bs_rem_q;
	logic        flag_q;
	logic [3:0]  step_q;

	logic [16:0] pi_t, ps_t;
	logic [15:0] pi_n, ps_n;
	logic [31:0] bi_prod, bs_prod;
	logic [15:0] bi_diff, bs_diff;

	// one restoring remainder step for the two page values
	always_comb begin
		pi_t = {pi_rem_q, pi_num_q[15]};
		ps_t = {ps_rem_q, ps_num_q[15]};
		pi_n = (pi_t >= {1'b0, div_q}) ? 16'(pi_t - {1'b0, div_q}) : pi_t[15:0];
		ps_n = (ps_t >= {1'b0, div_q}) ? 16'(ps_t - {1'b0, div_q}) : ps_t[15:0];
	end

	// remainder by 37 through a reciprocal multiply, quotient registered first
	always_comb begin
		bi_prod = {16'd0, bi_num_q} * {16'd0, omf_dh_pkg::BUCKET_RECIP};
		bs_prod = {16'd0, bs_num_q} * {16'd0, omf_dh_pkg::BUCKET_RECIP};
		bi_diff = bi_num_q - ({5'd0, bi_quo_q} * {10'd0, omf_dh_pkg::BUCKETS});
		bs_diff = bs_num_q - ({5'd0, bs_quo_q} * {10'd0, omf_dh_pkg::BUCKETS});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			omf_dh_pkg::BK_IDLE: if (!q_empty) state_d = omf_dh_pkg::BK_RUN;
			omf_dh_pkg::BK_RUN: if (step_q == '0) state_d = omf_dh_pkg::BK_HOLD;
			omf_dh_pkg::BK_HOLD: if (pop) state_d = omf_dh_pkg::BK_IDLE;
			default: state_d = omf_dh_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		empty = 1'b1;
		case (state_q)
			omf_dh_pkg::BK_IDLE: q_pop = !q_empty;
			omf_dh_pkg::BK_HOLD: empty = 1'b0;
			default: begin
				q_pop = 1'b0;
				empty = 1'b1;
			end
		endcase
	end

	assign page_index = pi_rem_q;
	assign page_step = (ps_rem_q == '0) ? 16'd1 : ps_rem_q;
	assign bucket_index = bi_rem_q;
	assign bucket_step = (bs_rem_q == '0) ? 6'd1 : bs_rem_q;
	assign name_too_long = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= omf_dh_pkg::BK_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				step_q <= 4'hF;
			end else if (state_q == omf_dh_pkg::BK_RUN) begin
				step_q <= step_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			div_q <= (page_count == '0) ? 16'd1 : page_count;
			pi_num_q <= q_entry.page_class;
			ps_num_q <= q_entry.page_inc;
			bi_num_q <= q_entry.bucket_class;
			bs_num_q <= q_entry.bucket_inc;
			flag_q <= q_entry.too_long;
			pi_rem_q <= '0;
			ps_rem_q <= '0;
			bi_rem_q <= '0;
			bs_rem_q <= '0;
		end else if (state_q == omf_dh_pkg::BK_RUN) begin
			pi_num_q <= {pi_num_q[14:0], 1'b0};
			ps_num_q <= {ps_num_q[14:0], 1'b0};
			pi_rem_q <= pi_n;
			ps_rem_q <= ps_n;
			if (step_q == 4'hF) begin
				bi_quo_q <= bi_prod[31:21];
				bs_quo_q <= bs_prod[31:21];
			end
			if (step_q == 4'hE) begin
				bi_rem_q <= bi_diff[5:0];
				bs_rem_q <= bs_diff[5:0];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == omf_dh_pkg::BK_RUN && step_q == '0) |=> (state_q == omf_dh_pkg::BK_HOLD))
		else $error("remainder run did not end in hold");
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == omf_dh_pkg::BK_HOLD) |->
		(bi_rem_q < omf_dh_pkg::BUCKETS && bs_rem_q < omf_dh_pkg::BUCKETS))
		else $error("bucket remainder out of range");
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == omf_dh_pkg::BK_HOLD) |-> (pi_rem_q < div_q && ps_rem_q < div_q))
		else $error("page remainder not below page count");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == omf_dh_pkg::BK_IDLE && !q_empty))
		else $error("queue popped outside idle");
`endif

endmodule

>>> design/omf_dictionary_hash.sv
// top level of the library dictionary hash block
// Name bytes are taken one per cycle, first to last, with last_byte on the final
// byte; each byte is hashed by the front end in the cycle it is accepted. A closed
// name goes into a two-entry queue, and the back end then reduces it with a
// bit-serial remainder unit for the page count, while the remainders by 37 come
// from a reciprocal multiply alongside: each name is loaded, taken through 16
// remainder steps and then held on the result ports until it is popped. Bytes
// keep streaming while the queue has room; full goes high only when two
// finished names wait behind the back end.
// page_count is written through the cfg channel, which is always ready.
module omf_dictionary_hash #(
	parameter int unsigned MAX_NAME_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  name_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] page_index,
	output logic [15:0] page_step,
	output logic [5:0]  bucket_index,
	output logic [5:0]  bucket_step,
	output logic        name_too_long
);

	logic [15:0]             page_count_q;
	logic                    accept, entry_push, q_pop, q_empty, out_pop;
	omf_dh_pkg::hash_entry_t new_entry, head_entry;

	assign cfg_ready = 1'b1;
	assign accept = push & ~full;
	assign out_pop = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			page_count_q <= cfg_data;
		end
	end

	omf_dh_front #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.name_byte(name_byte),
		.last_byte(last_byte),
		.entry_push(entry_push),
		.entry(new_entry)
	);

	omf_dh_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(entry_push),
		.wr_entry(new_entry),
		.pop(q_pop),
		.rd_entry(head_entry),
		.full(full),
		.empty(q_empty)
	);

	omf_dh_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.page_count(page_count_q),
		.q_empty(q_empty),
		.q_entry(head_entry),
		.q_pop(q_pop),
		.pop(out_pop),
		.empty(empty),
		.page_index(page_index),
		.page_step(page_step),
		.bucket_index(bucket_index),
		.bucket_step(bucket_step),
		.name_too_long(name_too_long)
	);

endmodule
